[rtl/msc_pkg.sv]
// Shared types and constants of the motor step speed controller.
package msc_pkg;

    // Widths of the configuration registers.
    localparam int TARGET_W   = 16;
    localparam int STEP_W     = 15;
    localparam int MIN_W      = 16;
    localparam int MAX_W      = 15;
    localparam int INTERVAL_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;

    // The time stamp keeps at most this many bits.
    localparam int NOW_MAX_W  = 32;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET_SPEED  = 3'd0,
        REG_DRIVE_STEP    = 3'd1,
        REG_DRIVE_MIN     = 3'd2,
        REG_DRIVE_MAX     = 3'd3,
        REG_POLL_INTERVAL = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [TARGET_W-1:0] target_speed;
        logic [STEP_W-1:0]          drive_step;
        logic signed [MIN_W-1:0]    drive_min;
        logic [MAX_W-1:0]           drive_max;
        logic [INTERVAL_W-1:0]      poll_interval;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        target_speed:  16'sd0,
        drive_step:    15'd328,
        drive_min:     -16'sd32768,
        drive_max:     15'd32767,
        poll_interval: 16'd50
    };

endpackage

[rtl/msc_update.sv]
// Poll check and drive update rule of the motor step speed controller.
module msc_update
    import msc_pkg::*;
#(
    parameter int VALUE_WIDTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  t_cfg                          i_cfg,
    input  logic [TIME_WIDTH-1:0]         i_last_poll,
    input  logic signed [VALUE_WIDTH-1:0] i_speed,
    input  logic signed [VALUE_WIDTH-1:0] i_applied,
    input  logic [TIME_WIDTH-1:0]         i_now,
    output logic                          o_due,
    output logic signed [VALUE_WIDTH-1:0] o_drive,
    output logic [TIME_WIDTH-1:0]         o_poll_ms
);

    localparam int CW    = ((VALUE_WIDTH > TARGET_W) ? VALUE_WIDTH : TARGET_W) + 2;
    localparam int NOW_W = (TIME_WIDTH > NOW_MAX_W) ? NOW_MAX_W : TIME_WIDTH;

    logic signed [CW-1:0] speed_x;
    logic signed [CW-1:0] applied_x;
    logic signed [CW-1:0] target_x;
    logic signed [CW-1:0] step_x;
    logic signed [CW-1:0] min_x;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] speed_mag;
    logic signed [CW-1:0] target_mag;
    logic signed [CW-1:0] up_sum;
    logic signed [CW-1:0] dn_sum;
    logic signed [CW-1:0] stepped;
    logic [TIME_WIDTH-1:0] due_at;

    // The time stamp is taken at no more than 32 bits; the due time wraps.
    assign o_poll_ms = TIME_WIDTH'(i_now[NOW_W-1:0]);
    assign due_at    = i_last_poll + TIME_WIDTH'(i_cfg.poll_interval);
    assign o_due     = (i_last_poll == '0) || (o_poll_ms >= due_at);

    assign speed_x   = CW'(i_speed);
    assign applied_x = CW'(i_applied);
    assign target_x  = CW'(i_cfg.target_speed);
    assign step_x    = signed'(CW'(i_cfg.drive_step));
    assign min_x     = CW'(i_cfg.drive_min);
    assign max_x     = signed'(CW'(i_cfg.drive_max));

    assign speed_mag  = speed_x[CW-1] ? -speed_x : speed_x;
    assign target_mag = target_x[CW-1] ? -target_x : target_x;
    assign up_sum     = applied_x + step_x;
    assign dn_sum     = applied_x - step_x;

    always_comb begin
        stepped = applied_x;
        if ((speed_x != '0) && (speed_x[CW-1] != target_x[CW-1])) begin
            // Running the wrong way: release the drive.
            stepped = '0;
        end else if (speed_mag > target_mag) begin
            // Too fast: step toward zero without crossing it.
            if (!applied_x[CW-1]) begin
                stepped = dn_sum[CW-1] ? '0 : dn_sum;
            end else begin
                stepped = (!up_sum[CW-1] && (up_sum != '0)) ? '0 : up_sum;
            end
        end else if (speed_mag < target_mag) begin
            // Too slow: step away from zero, held inside the drive limits.
            if (!applied_x[CW-1]) begin
                stepped = (up_sum > max_x) ? max_x : up_sum;
            end else begin
                stepped = (dn_sum < min_x) ? min_x : dn_sum;
            end
        end
    end

    assign o_drive = (i_cfg.target_speed == '0) ? '0 : stepped[VALUE_WIDTH-1:0];

endmodule

[rtl/motor_step_speed_controller_top.sv]
// Top level of the motor step speed controller: ports, pipeline and state.
//
// Usage:
// Each input beat carries a measured speed, the drive currently applied and a
// millisecond time stamp. When the controller has never polled, or the poll
// interval has elapsed since the last recorded poll, it computes a new drive
// value, records the time stamp and returns the drive with updated set.
// Otherwise it returns the stored drive with updated clear. Every input beat
// produces exactly one output beat, in order.
// Both channels use valid/ready. An input beat is first captured in an input
// register; the update rule then runs on it and the result lands in the
// output register. One beat is accepted per cycle while the output drains;
// the update loop through the stored drive and poll time is combinational
// and sets that rate.
// When the receiver stalls, the output beat holds and the input register
// still takes one more beat; the input side then backs off until the output
// drains. Configuration registers are written through a plain write port and
// are meant to change only while no beat is in flight.
// Reset (synchronous, active low) empties the pipeline, restores the register
// defaults and clears the stored drive and poll time.
module motor_step_speed_controller_top
    import msc_pkg::*;
#(
    parameter int VALUE_WIDTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]         i_cfg_wdata,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_measured_speed,
    input  logic signed [VALUE_WIDTH-1:0] i_applied_drive,
    input  logic [TIME_WIDTH-1:0]         i_now_ms,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_updated,
    output logic signed [VALUE_WIDTH-1:0] o_drive_out
);

    t_cfg r_cfg;

    // Input register.
    logic                          r_s1_valid;
    logic signed [VALUE_WIDTH-1:0] r_s1_speed;
    logic signed [VALUE_WIDTH-1:0] r_s1_applied;
    logic [TIME_WIDTH-1:0]         r_s1_now;

    // Controller state.
    logic [TIME_WIDTH-1:0]         r_last_poll;
    logic signed [VALUE_WIDTH-1:0] r_drive;

    // Output register.
    logic                          r_out_valid;
    logic                          r_out_updated;
    logic signed [VALUE_WIDTH-1:0] r_out_drive;

    logic                          in_beat;
    logic                          s1_go;
    logic                          due;
    logic signed [VALUE_WIDTH-1:0] new_drive;
    logic [TIME_WIDTH-1:0]         poll_ms;
    logic signed [VALUE_WIDTH-1:0] n_drive;

    // The input register moves on whenever the output register is empty or
    // is being drained in this cycle.
    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_beat    = i_in_valid && o_in_ready;

    msc_update #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_update (
        .i_cfg       (r_cfg),
        .i_last_poll (r_last_poll),
        .i_speed     (r_s1_speed),
        .i_applied   (r_s1_applied),
        .i_now       (r_s1_now),
        .o_due       (due),
        .o_drive     (new_drive),
        .o_poll_ms   (poll_ms)
    );

    // A beat that is not due returns the drive already stored.
    assign n_drive = due ? new_drive : r_drive;

    // The step and max registers keep only their low bits; unknown indexes are
    // dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_TARGET_SPEED:  r_cfg.target_speed  <= i_cfg_wdata;
                REG_DRIVE_STEP:    r_cfg.drive_step    <= i_cfg_wdata[STEP_W-1:0];
                REG_DRIVE_MIN:     r_cfg.drive_min     <= i_cfg_wdata;
                REG_DRIVE_MAX:     r_cfg.drive_max     <= i_cfg_wdata[MAX_W-1:0];
                REG_POLL_INTERVAL: r_cfg.poll_interval <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control state: valid flags and the controller's own memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_poll <= '0;
            r_drive     <= '0;
        end else begin
            if (in_beat) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_go && due) begin
                r_last_poll <= poll_ms;
                r_drive     <= new_drive;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_speed   <= i_measured_speed;
            r_s1_applied <= i_applied_drive;
            r_s1_now     <= i_now_ms;
        end
        if (s1_go) begin
            r_out_updated <= due;
            r_out_drive   <= n_drive;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_updated   = r_out_updated;
    assign o_drive_out = r_out_drive;

endmodule

[rtl/msc_checker.sv]
// Port-level assertions for the motor step speed controller, bound to the top.
module msc_checker #(
    parameter int VALUE_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_updated,
    input logic signed [VALUE_WIDTH-1:0] o_drive_out
);

    logic                          out_beat;
    logic signed [VALUE_WIDTH-1:0] r_prev_drive;

    assign out_beat = o_out_valid && i_out_ready;

    // Drive of the last delivered beat; zero after reset like the stored drive.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_drive <= '0;
        end else if (out_beat) begin
            r_prev_drive <= o_drive_out;
        end
    end

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_updated) && $stable(o_drive_out))
        else $error("output beat changed while stalled");

    // With the output register empty the pipeline always takes a beat.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A beat without an update repeats the stored drive.
    a_hold_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && !o_updated |-> o_drive_out == r_prev_drive)
        else $error("drive changed without an update");

endmodule

bind motor_step_speed_controller_top msc_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_msc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_updated   (o_updated),
    .o_drive_out (o_drive_out)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the motor step speed controller: directed and random beats.
module tb_top;
    import msc_pkg::*;

    localparam int VW             = 16;
    localparam int TW             = 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 10;
    localparam int BEATS_PER_PHASE = 120;
    // First index past the register list; writes there must leave every register alone.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd5;

    typedef struct packed {
        logic signed [VW-1:0] speed;
        logic signed [VW-1:0] applied;
        logic [TW-1:0]        now_ms;
    } t_speed_sample;

    typedef struct packed {
        logic                 updated;
        logic signed [VW-1:0] drive;
    } t_drive_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic signed [VW-1:0]  i_measured_speed = '0;
    logic signed [VW-1:0]  i_applied_drive = '0;
    logic [TW-1:0]         i_now_ms = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_updated;
    logic signed [VW-1:0]  o_drive_out;

    motor_step_speed_controller_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_measured_speed (i_measured_speed),
        .i_applied_drive  (i_applied_drive),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_updated        (o_updated),
        .o_drive_out      (o_drive_out)
    );

    always #5 i_clk = ~i_clk;

    // Controller copy kept by the testbench: register values, last poll time and held drive.
    t_cfg                 ctl_cfg = CFG_RESET;
    logic [TW-1:0]        last_poll = '0;
    logic signed [VW-1:0] held_drive = '0;

    t_speed_sample sample_queue[$];   // beats waiting to be offered to the block
    t_drive_result drive_expect[$];   // drive results predicted for accepted beats
    int n_queued = 0;
    int n_accepted = 0;
    int n_fail = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_cycles = 0;

    // Runs one poll of the controller on an accepted beat and returns the drive it reports.
    function automatic t_drive_result apply_sample(t_speed_sample s);
        t_drive_result r;
        logic [TW-1:0] due_at;
        int spd, tgt, spd_mag, tgt_mag, d, step, dmin, dmax;
        spd     = $signed(s.speed);
        tgt     = $signed(ctl_cfg.target_speed);
        step    = ctl_cfg.drive_step;
        dmin    = $signed(ctl_cfg.drive_min);
        dmax    = ctl_cfg.drive_max;
        spd_mag = (spd < 0) ? -spd : spd;
        tgt_mag = (tgt < 0) ? -tgt : tgt;
        due_at  = last_poll + ctl_cfg.poll_interval;
        r.updated = 1'b0;
        // A zero last poll time means the controller has never polled.
        if (last_poll == '0 || s.now_ms >= due_at) begin
            if (tgt == 0) begin
                held_drive = '0;
            end else begin
                d = $signed(s.applied);
                if (spd != 0 && ((spd < 0) != (tgt < 0))) begin
                    d = 0;
                end else if (spd_mag > tgt_mag) begin
                    // Too fast: move toward zero without crossing it.
                    if (d >= 0) begin
                        d = d - step;
                        if (d < 0) d = 0;
                    end else begin
                        d = d + step;
                        if (d > 0) d = 0;
                    end
                end else if (spd_mag < tgt_mag) begin
                    // Too slow: move away from zero, clamped to the limit on that side.
                    if (d >= 0) begin
                        d = d + step;
                        if (d > dmax) d = dmax;
                    end else begin
                        d = d - step;
                        if (d < dmin) d = dmin;
                    end
                end
                held_drive = d[VW-1:0];
            end
            last_poll = s.now_ms;
            r.updated = 1'b1;
        end
        r.drive = held_drive;
        return r;
    endfunction

    // Writes one register; only called while no beat is in flight.
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (addr)
            REG_TARGET_SPEED:  ctl_cfg.target_speed  = data;
            REG_DRIVE_STEP:    ctl_cfg.drive_step    = data[STEP_W-1:0];
            REG_DRIVE_MIN:     ctl_cfg.drive_min     = data;
            REG_DRIVE_MAX:     ctl_cfg.drive_max     = data[MAX_W-1:0];
            REG_POLL_INTERVAL: ctl_cfg.poll_interval = data;
            default: ;
        endcase
    endtask

    task automatic add_sample(input logic [VW-1:0] speed, input logic [VW-1:0] applied,
                              input logic [TW-1:0] now_ms);
        t_speed_sample s;
        s.speed   = speed;
        s.applied = applied;
        s.now_ms  = now_ms;
        sample_queue.push_back(s);
        n_queued++;
    endtask

    // The sender holds back until every queued beat is accepted and every result is back.
    // It then lets the pipeline settle before the next register write.
    task automatic drain();
        while (n_accepted != n_queued || drive_expect.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Input driver. A beat is predicted at the edge where it is accepted, then the next one
    // is offered only once the current slot is free, so valid never drops before acceptance.
    always @(posedge i_clk) begin : drv_proc
        t_speed_sample beat;
        t_speed_sample nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                beat.speed   = i_measured_speed;
                beat.applied = i_applied_drive;
                beat.now_ms  = i_now_ms;
                drive_expect.push_back(apply_sample(beat));
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = sample_queue.pop_front();
                    i_in_valid       <= 1'b1;
                    i_measured_speed <= nxt.speed;
                    i_applied_drive  <= nxt.applied;
                    i_now_ms         <= nxt.now_ms;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: every accepted output beat is matched against the oldest prediction.
    always @(posedge i_clk) begin : mon_proc
        t_drive_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (drive_expect.size() == 0) begin
                    $error("output beat with nothing expected: updated=%0b drive_out=%0d",
                           o_updated, o_drive_out);
                    n_fail++;
                end else begin
                    want = drive_expect.pop_front();
                    if (o_updated !== want.updated) begin
                        $error("updated: expected %0b, actual %0b", want.updated, o_updated);
                        n_fail++;
                    end
                    if (o_drive_out !== want.drive) begin
                        $error("drive_out: expected %0d, actual %0d", want.drive, o_drive_out);
                        n_fail++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: counts cycles with work outstanding and no beat moving on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (n_accepted == n_queued && drive_expect.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stim
        logic [TW-1:0] gen_ms;
        logic [15:0]   w_target, w_step, w_min, w_max, w_interval, spd, app;
        int            tgt, sel;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Target zero after reset: the first poll is due because nothing was recorded yet,
        // a beat inside the interval is not, and one exactly at the interval edge is.
        add_sample(16'sd100, 16'sd5000, 32'd10);
        add_sample(16'sd100, 16'sd5000, 32'd20);
        add_sample(16'sd100, 16'sd5000, 32'd60);
        drain();

        // Positive target: too fast and too slow on both drive signs, clamps at zero and at
        // the full-scale limits, on target, opposite direction and a stopped motor.
        cfg_write(REG_TARGET_SPEED, 16'd1000);
        add_sample(16'sd1200, 16'sd1000, 32'd200);
        add_sample(16'sd1200, 16'sd100, 32'd300);
        add_sample(16'sd1200, -16'sd100, 32'd400);
        add_sample(16'sd1200, -16'sd1000, 32'd500);
        add_sample(16'sd500, 16'sd32700, 32'd600);
        add_sample(16'sd500, -16'sd32700, 32'd700);
        add_sample(16'sd1000, 16'sd1234, 32'd800);
        add_sample(-16'sd5, 16'sd5000, 32'd900);
        add_sample(16'sd0, 16'sd5000, 32'd1000);
        add_sample(16'sd32767, 16'sd32767, 32'd1100);
        add_sample(16'h8000, 16'h8000, 32'd1110);
        // A beat at time zero falls short of the due time, so it is not recorded and the next beat is not due either.
        add_sample(16'h8000, 16'h8000, 32'd0);
        add_sample(16'sd700, 16'sd200, 32'd5);
        drain();

        // Most negative target, step and max written with their unused top bit set, a
        // positive minimum pattern, zero interval, and a write past the register list.
        cfg_write(REG_TARGET_SPEED, 16'h8000);
        cfg_write(REG_DRIVE_STEP, 16'hFFFF);
        cfg_write(REG_DRIVE_MIN, 16'h0100);
        cfg_write(REG_DRIVE_MAX, 16'h83E8);
        cfg_write(REG_POLL_INTERVAL, 16'd0);
        cfg_write(REG_SPARE_LO, 16'hFFFF);
        add_sample(16'h8000, -16'sd5, 32'd2000);
        add_sample(-16'sd100, -16'sd5, 32'd2000);
        add_sample(-16'sd100, 16'sd5000, 32'd2001);
        add_sample(-16'sd100, 16'sd32767, 32'd2002);
        add_sample(16'sd100, -16'sd7, 32'd2003);
        drain();

        // Longest interval with the due time wrapping past the top of the time range.
        cfg_write(REG_TARGET_SPEED, 16'd32767);
        cfg_write(REG_POLL_INTERVAL, 16'hFFFF);
        add_sample(16'sd10, 16'sd10, 32'hFFFF_FFF0);
        add_sample(16'sd10, 16'sd10, 32'd5);
        add_sample(16'sd10, 16'sd10, 32'hFFFF_FFFF);
        drain();

        gen_ms = 32'd100;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // Register settings: the first two phases take the extremes, the rest a mix.
            if (p == 0) begin
                w_target = 16'h8000; w_step = 16'd0; w_min = 16'h8000;
                w_max = 16'd0; w_interval = 16'd0;
            end else if (p == 1) begin
                w_target = 16'h7FFF; w_step = 16'h7FFF; w_min = 16'd0;
                w_max = 16'h7FFF; w_interval = 16'hFFFF;
            end else begin
                case ($urandom_range(4))
                    0: w_target = 16'd0;
                    1: w_target = 16'h8000;
                    2: w_target = 16'h7FFF;
                    3: w_target = 16'(int'($urandom_range(2000)) - 1000);
                    default: w_target = 16'($urandom);
                endcase
                case ($urandom_range(4))
                    0: w_step = 16'd0;
                    1: w_step = 16'd1;
                    2: w_step = 16'hFFFF;
                    3: w_step = 16'($urandom_range(1000, 1));
                    default: w_step = 16'($urandom);
                endcase
                case ($urandom_range(4))
                    0: w_min = 16'h8000;
                    1: w_min = 16'd0;
                    2: w_min = 16'(-int'($urandom_range(2000, 1)));
                    3: w_min = 16'($urandom);
                    default: w_min = 16'(-int'($urandom_range(32768, 20000)));
                endcase
                case ($urandom_range(3))
                    0: w_max = 16'd0;
                    1: w_max = 16'h7FFF;
                    2: w_max = 16'($urandom_range(2000, 1));
                    default: w_max = 16'($urandom);
                endcase
                case ($urandom_range(3))
                    0: w_interval = 16'd0;
                    1: w_interval = 16'd1;
                    2: w_interval = 16'hFFFF;
                    default: w_interval = 16'($urandom_range(200, 2));
                endcase
            end
            cfg_write(REG_TARGET_SPEED, w_target);
            cfg_write(REG_DRIVE_STEP, w_step);
            cfg_write(REG_DRIVE_MIN, w_min);
            cfg_write(REG_DRIVE_MAX, w_max);
            cfg_write(REG_POLL_INTERVAL, w_interval);
            if (p % 3 == 2) cfg_write(REG_SPARE_LO + 3'($urandom_range(2)), 16'($urandom));

            // Handshake pressure cycles through: none, sender idle, receiver stall, both.
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase

            tgt = $signed(ctl_cfg.target_speed);
            for (int k = 0; k < BEATS_PER_PHASE; k++) begin
                // Time mostly advances around the poll interval so both due and early polls
                // occur; others jump anywhere, return to zero, sit near the wrap point or keep the last time.
                sel = $urandom_range(99);
                if (sel < 70) begin
                    gen_ms = gen_ms + $urandom_range(2 * ctl_cfg.poll_interval + 2);
                end else if (sel < 80) begin
                    gen_ms = $urandom;
                end else if (sel < 85) begin
                    gen_ms = '0;
                end else if (sel < 90) begin
                    gen_ms = 32'hFFFF_FFFF - $urandom_range(200);
                end

                sel = $urandom_range(99);
                if (sel < 30) spd = 16'(tgt + int'($urandom_range(6)) - 3);
                else if (sel < 40) spd = 16'(-tgt);
                else if (sel < 50) begin
                    case ($urandom_range(2))
                        0: spd = 16'h8000;
                        1: spd = 16'h7FFF;
                        default: spd = 16'd0;
                    endcase
                end else spd = 16'($urandom);

                sel = $urandom_range(99);
                if (sel < 20) app = 16'(int'(ctl_cfg.drive_max) - int'($urandom_range(400)));
                else if (sel < 40)
                    app = 16'(int'($signed(ctl_cfg.drive_min)) + int'($urandom_range(400)));
                else if (sel < 55) app = 16'(int'($urandom_range(800)) - 400);
                else if (sel < 65) app = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
                else app = 16'($urandom);

                add_sample(spd, app, gen_ms);
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (n_fail == 0 && drive_expect.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
